[sv/bst_pkg.sv]
// Shared types, register codes and reset values for the bright spot tracker.
// Used by every module of the block but bst_div; depends on nothing.
package bst_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_LVL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam logic [7:0]  RST_BRIGHTNESS_FLOOR = 8'd200;
    localparam logic [3:0]  RST_AVERAGE_PERIOD   = 4'd5;
    localparam logic [11:0] RST_SCREEN_WIDTH     = 12'd1280;
    localparam logic [11:0] RST_SCREEN_HEIGHT    = 12'd760;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT    = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] pixel_x;
        logic [8:0] pixel_y;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic [9:0]  average_x;
        logic [8:0]  average_y;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic        spot_found;
    } t_result;

    typedef struct packed {
        logic [7:0]  brightness_floor;
        logic [3:0]  average_period;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
    } t_cfg;

    // One record per completed frame, handed from the search to the averaging.
    typedef struct packed {
        logic       found;
        logic [9:0] cand_x;
        logic [8:0] cand_y;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LX,
        BK_WX,
        BK_LY,
        BK_WY,
        BK_MAP,
        BK_SCALE,
        BK_OUT
    } t_back_state;

endpackage

[sv/bst_div.sv]
// Restoring shift-and-subtract divider, one quotient bit per cycle.
// Used by bst_back for the two averages; no dependencies.
module bst_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= DVS_W'(w_trial - {1'b0, r_dvs});
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/bst_front.sv]
// Pixel search: tracks the brightest qualifying pixel of the current frame
// and posts one record per frame into the queue. Depends on bst_pkg.
module bst_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bst_pkg::t_cfg       i_cfg,
    input  logic                i_accept,
    input  bst_pkg::t_pixel     i_pixel,
    output logic                o_push,
    output bst_pkg::t_frame_rec o_rec
);
    import bst_pkg::*;

    logic [7:0] r_peak;
    logic       r_found;
    logic [9:0] r_cand_x;
    logic [8:0] r_cand_y;
    logic [7:0] w_bright;
    logic [7:0] w_level;
    logic       w_hit;

    always_comb begin
        w_bright = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue > w_bright) begin
            w_bright = i_pixel.blue;
        end
    end

    // Until a pixel qualifies the live floor register is the bar to beat.
    assign w_level = r_found ? r_peak : i_cfg.brightness_floor;
    assign w_hit   = w_bright > w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_peak  <= RST_BRIGHTNESS_FLOOR;
        end else if (i_accept) begin
            if (i_pixel.frame_end) begin
                r_found <= 1'b0;
                r_peak  <= i_cfg.brightness_floor;
            end else if (w_hit) begin
                r_found <= 1'b1;
                r_peak  <= w_bright;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_hit) begin
            r_cand_x <= i_pixel.pixel_x;
            r_cand_y <= i_pixel.pixel_y;
        end
    end

    assign o_push       = i_accept && i_pixel.frame_end;
    assign o_rec.found  = r_found || w_hit;
    assign o_rec.cand_x = w_hit ? i_pixel.pixel_x : r_cand_x;
    assign o_rec.cand_y = w_hit ? i_pixel.pixel_y : r_cand_y;

endmodule

[sv/bst_queue.sv]
// Short FIFO of frame records between the pixel search and the averaging.
// Depends on bst_pkg for the record type and depth.
module bst_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bst_pkg::t_frame_rec    i_rec,
    input  logic                   i_pop,
    output bst_pkg::t_frame_rec    o_rec,
    output bst_pkg::t_queue_status o_status
);
    import bst_pkg::*;

    t_frame_rec         r_entry [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_LVL_W-1:0] r_level;

    function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] ptr);
        return (ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + Q_LVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - Q_LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_rec;
        end
    end

    assign o_rec          = r_entry[r_rd_ptr];
    assign o_status.full  = r_level == Q_LVL_W'(QUEUE_DEPTH);
    assign o_status.empty = r_level == '0;

endmodule

[sv/bst_back.sv]
// Averaging and screen mapping: takes one frame record at a time, updates the
// running sums and drives the result register. Depends on bst_pkg, bst_div.
module bst_back #(
    parameter int FRAME_WIDTH  = bst_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = bst_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bst_pkg::t_cfg          i_cfg,
    input  bst_pkg::t_queue_status i_q_status,
    input  bst_pkg::t_frame_rec    i_rec,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output bst_pkg::t_result       o_result
);
    import bst_pkg::*;

    localparam int FHW    = $clog2(FRAME_HEIGHT + 1);
    localparam int PRX_W  = 22;
    localparam int PRY_W  = FHW + 12;
    localparam int DVD_W  = 14;
    localparam int DVS_W  = 4;

    // Division by a frame dimension is a multiply by the reciprocal, rounded up,
    // followed by a shift; the shift is long enough to be exact for any product.
    localparam int RSX_SH = PRX_W + $clog2(FRAME_WIDTH);
    localparam int RSY_SH = PRY_W + $clog2(FRAME_HEIGHT);
    localparam int RCX_W  = PRX_W + 2;
    localparam int RCY_W  = PRY_W + 2;
    localparam int MX_W   = RSX_SH + PRX_W;
    localparam int MY_W   = RSY_SH + PRY_W;
    localparam logic [RCX_W-1:0] RCP_X =
        RCX_W'((64'd1 << RSX_SH) / 64'(FRAME_WIDTH) + 64'd1);
    localparam logic [RCY_W-1:0] RCP_Y =
        RCY_W'((64'd1 << RSY_SH) / 64'(FRAME_HEIGHT) + 64'd1);

    t_back_state r_state;
    t_back_state n_state;

    logic [9:0]       r_spot_x;
    logic [8:0]       r_spot_y;
    logic [13:0]      r_sum_x;
    logic [12:0]      r_sum_y;
    logic [3:0]       r_count;
    logic             r_found;
    logic [PRX_W-1:0] r_prod_x;
    logic [PRY_W-1:0] r_prod_y;
    logic [11:0]      r_scr_x;
    logic [11:0]      r_scr_y;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_pop;
    logic             w_start;
    logic             w_load;
    logic [DVD_W-1:0] w_dividend;
    logic [DVS_W-1:0] w_divisor;
    logic             w_done;
    logic [DVD_W-1:0] w_quo;
    logic [9:0]       w_cx;
    logic [8:0]       w_cy;
    logic [3:0]       w_count_inc;
    logic [FHW-1:0]   w_dy;
    logic [PRX_W-1:0] w_prod_x;
    logic [PRY_W-1:0] w_prod_y;
    logic [MX_W-1:0]  w_mul_x;
    logic [MY_W-1:0]  w_mul_y;
    logic [PRX_W-1:0] w_quo_x;
    logic [PRY_W-1:0] w_quo_y;

    bst_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_dividend(w_dividend),
        .i_divisor (w_divisor),
        .o_done    (w_done),
        .o_quotient(w_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (!i_q_status.empty) n_state = BK_LX;
            BK_LX:    n_state = BK_WX;
            BK_WX:    if (w_done) n_state = BK_LY;
            BK_LY:    n_state = BK_WY;
            BK_WY:    if (w_done) n_state = BK_MAP;
            BK_MAP:   n_state = BK_SCALE;
            BK_SCALE: n_state = BK_OUT;
            BK_OUT:   if (!r_out_valid || i_ready) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_pop      = 1'b0;
        w_start    = 1'b0;
        w_load     = 1'b0;
        w_dividend = '0;
        w_divisor  = DVS_W'(1);
        case (r_state)
            BK_IDLE: w_pop = !i_q_status.empty;
            BK_LX: begin
                w_start    = 1'b1;
                w_dividend = DVD_W'(r_sum_x);
                w_divisor  = DVS_W'(r_count);
            end
            BK_LY: begin
                w_start    = 1'b1;
                w_dividend = DVD_W'(r_sum_y);
                w_divisor  = DVS_W'(r_count);
            end
            BK_OUT:  w_load = !r_out_valid || i_ready;
            default: w_pop = 1'b0;
        endcase
    end

    // A frame without a qualifying pixel contributes the previous average.
    assign w_cx        = i_rec.found ? i_rec.cand_x : r_spot_x;
    assign w_cy        = i_rec.found ? i_rec.cand_y : r_spot_y;
    assign w_count_inc = (r_count == 4'hF) ? 4'd1 : r_count + 4'd1;

    // Rows at or below the frame height map to the bottom edge, so the
    // multiplicand is forced to zero; otherwise the row fits in FHW bits.
    assign w_dy     = (32'(r_spot_y) >= FRAME_HEIGHT) ? '0
                      : FHW'(FRAME_HEIGHT) - FHW'(r_spot_y);
    assign w_prod_x = PRX_W'(r_spot_x) * PRX_W'(i_cfg.screen_width);
    assign w_prod_y = PRY_W'(w_dy) * PRY_W'(i_cfg.screen_height);

    assign w_mul_x  = MX_W'(r_prod_x) * MX_W'(RCP_X);
    assign w_mul_y  = MY_W'(r_prod_y) * MY_W'(RCP_Y);
    assign w_quo_x  = w_mul_x[RSX_SH +: PRX_W];
    assign w_quo_y  = w_mul_y[RSY_SH +: PRY_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_spot_x <= '0;
            r_spot_y <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_count  <= '0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                r_sum_x <= r_sum_x + 14'(w_cx);
                r_sum_y <= r_sum_y + 13'(w_cy);
                r_count <= w_count_inc;
            end
            if (r_state == BK_WX && w_done) begin
                r_spot_x <= w_quo[9:0];
            end
            if (r_state == BK_WY && w_done) begin
                r_spot_y <= w_quo[8:0];
                if (r_count >= i_cfg.average_period) begin
                    r_count <= 4'd1;
                    r_sum_x <= 14'(r_spot_x);
                    r_sum_y <= 13'(w_quo[8:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_found <= i_rec.found;
        end
        if (r_state == BK_MAP) begin
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
        if (r_state == BK_SCALE) begin
            r_scr_x <= (w_quo_x > PRX_W'(i_cfg.screen_width)) ? i_cfg.screen_width
                       : w_quo_x[11:0];
            r_scr_y <= (w_quo_y > PRY_W'(i_cfg.screen_height)) ? i_cfg.screen_height
                       : w_quo_y[11:0];
        end
        if (w_load) begin
            r_out.average_x  <= r_spot_x;
            r_out.average_y  <= r_spot_y;
            r_out.screen_x   <= r_scr_x;
            r_out.screen_y   <= r_scr_y;
            r_out.spot_found <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pop    = w_pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[sv/bright_spot_tracker.sv]
// Top level of the bright spot tracker: configuration registers, pixel search,
// frame record queue and averaging back end. Depends on bst_pkg and submodules.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------
//   pixel   | in        | i_in_valid / o_in_ready   | i_in_pixel  (t_pixel)
//   result  | out       | o_out_valid / i_out_ready | o_out_result (t_result)
//   config  | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// Pixels are taken one per cycle while the record queue has room; a frame end
// pixel posts a record, and the pixel search carries on at once.
// In the back end each frame record goes through the bit-serial divider, which
// forms both averages in turn over the 14-bit sum, and then the screen mapping,
// a reciprocal multiply registered in the BK_MAP and BK_SCALE states.
// A stalled result holds in the output register while pixels keep flowing;
// once four frame records are queued the pixel input stalls.
// Reset is synchronous and active low; there is no clearing pass.
module bright_spot_tracker #(
    parameter int FRAME_WIDTH  = bst_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = bst_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bst_pkg::t_pixel                 i_in_pixel,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bst_pkg::t_result                o_out_result,
    input  logic                            i_cfg_we,
    input  logic [bst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bst_pkg::*;

    t_cfg          r_cfg;
    t_queue_status w_q_status;
    t_frame_rec    w_push_rec;
    t_frame_rec    w_pop_rec;
    logic          w_push;
    logic          w_pop;
    logic          w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness_floor <= RST_BRIGHTNESS_FLOOR;
            r_cfg.average_period   <= RST_AVERAGE_PERIOD;
            r_cfg.screen_width     <= RST_SCREEN_WIDTH;
            r_cfg.screen_height    <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRIGHTNESS_FLOOR: r_cfg.brightness_floor <= i_cfg_data[7:0];
                REG_AVERAGE_PERIOD:   r_cfg.average_period   <= i_cfg_data[3:0];
                REG_SCREEN_WIDTH:     r_cfg.screen_width     <= i_cfg_data;
                REG_SCREEN_HEIGHT:    r_cfg.screen_height    <= i_cfg_data;
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_in_ready = !w_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;

    bst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_accept(w_accept),
        .i_pixel (i_in_pixel),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    bst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_status(w_q_status)
    );

    bst_back #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_status(w_q_status),
        .i_rec     (w_pop_rec),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_result  (o_out_result)
    );

    // The mapped coordinates never exceed the configured screen size.
    a_screen_x_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_result.screen_x <= r_cfg.screen_width)
        else $error("screen_x beyond screen width");

    a_screen_y_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_result.screen_y <= r_cfg.screen_height)
        else $error("screen_y beyond screen height");

    // A frame record is never written into a full queue, nor read from an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_q_status.full || w_pop))
        else $error("frame record pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("frame record popped from empty queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

endmodule
